// ===== hw/rtl/mhd_conservative_to_primitive_core_assert.svh =====
// ----------------------------------------------------------------------------
// MHD conservative-to-primitive assertion macros
// Shared concurrent check forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef MHD_CONSERVATIVE_TO_PRIMITIVE_CORE_ASSERT_SVH
`define MHD_CONSERVATIVE_TO_PRIMITIVE_CORE_ASSERT_SVH

// Same-cycle implication.
`define MHD_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mhd_c2p check failed");

// Implication on a value sampled a fixed number of edges back.
`define MHD_CHECK_PAST(lbl, ante, cond, depth) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> $past(cond, depth)) \
    else $error("mhd_c2p latency check failed");

`endif

// ===== hw/rtl/mhd_c2p_pkg.sv =====
// ----------------------------------------------------------------------------
// MHD conservative-to-primitive package
// Widths, shared types and saturation helpers for the conversion pipeline.
// ----------------------------------------------------------------------------
package mhd_c2p_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int GAMMA_FRAC = 16;
  localparam int GAMMA_W    = 19;
  localparam int WORD_W     = 32;
  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 31;
  localparam int LANES      = 4;
  localparam int KIN_LANE   = 3;
  localparam int BSQ_W      = 64 - FRAC_BITS;
  // input register, square, sum, divider stages, four post stages, output
  localparam int LATENCY    = 3 + DIVIDEND_W + 5;

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = GAMMA_W'(43691);

  typedef logic [DIVIDEND_W-1:0] dividend_t;

  typedef struct packed {
    logic [WORD_W-1:0]      density;
    logic [2:0][WORD_W-1:0] field;
    logic [WORD_W-1:0]      energy;
    logic [BSQ_W-1:0]       bsq;
    logic [2:0]             m_neg;
    logic                   bad;
  } side_t;

  typedef struct packed {
    logic [WORD_W-1:0]      density;
    logic [2:0][WORD_W-1:0] field;
    logic [2:0][WORD_W-1:0] vel;
    logic                   bad;
  } res_t;

  function automatic logic [WORD_W-1:0] abs_word(input logic [WORD_W-1:0] x);
    abs_word = x[WORD_W-1] ? (~x + WORD_W'(1)) : x;
  endfunction

  // Apply sign to a magnitude and clamp to the signed word range.
  function automatic logic [WORD_W-1:0] sat_word(input logic neg, input logic [63:0] mag);
    logic [63:0] neg_mag;
    neg_mag = ~mag + 64'd1;
    if (neg) begin
      sat_word = (mag >= 64'h8000_0000) ? 32'h8000_0000 : neg_mag[WORD_W-1:0];
    end else begin
      sat_word = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[WORD_W-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/mhd_c2p_div.sv =====
// ----------------------------------------------------------------------------
// MHD conservative-to-primitive divider
// Four-lane restoring divider with a shared divisor, one quotient bit a stage.
// ----------------------------------------------------------------------------
module mhd_c2p_div (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  in_valid,
  input  logic [mhd_c2p_pkg::DIVISOR_W-1:0]                     divisor,
  input  mhd_c2p_pkg::dividend_t [mhd_c2p_pkg::LANES-1:0]       dividend,
  output logic                                                  out_valid,
  output mhd_c2p_pkg::dividend_t [mhd_c2p_pkg::LANES-1:0]       quotient
);

  localparam int STAGES = mhd_c2p_pkg::DIVIDEND_W;
  localparam int DW     = mhd_c2p_pkg::DIVISOR_W;
  localparam int NL     = mhd_c2p_pkg::LANES;

  logic [STAGES-1:0]      vld;
  logic [DW-1:0]          dsr [STAGES];
  logic [DW-1:0]          rem [STAGES][NL];
  mhd_c2p_pkg::dividend_t nq  [STAGES][NL];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic                   vin;
    logic [DW-1:0]          din;
    logic [DW-1:0]          rin [NL];
    mhd_c2p_pkg::dividend_t qin [NL];

    if (k == 0) begin : g_first
      assign vin = in_valid;
      assign din = divisor;
      for (genvar j = 0; j < NL; j++) begin : g_lane_in
        assign rin[j] = '0;
        assign qin[j] = dividend[j];
      end
    end else begin : g_next
      assign vin = vld[k-1];
      assign din = dsr[k-1];
      for (genvar j = 0; j < NL; j++) begin : g_lane_in
        assign rin[j] = rem[k-1][j];
        assign qin[j] = nq[k-1][j];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      dsr[k] <= din;
    end

    for (genvar j = 0; j < NL; j++) begin : g_lane
      logic [DW:0] trial;
      logic        fits;
      assign trial = {rin[j], qin[j][mhd_c2p_pkg::DIVIDEND_W-1]};
      assign fits  = trial >= {1'b0, din};

      // keep remainder below the divisor, shift the quotient bit in
      always_ff @(posedge clk) begin
        rem[k][j] <= fits ? DW'(trial - {1'b0, din}) : trial[DW-1:0];
        nq[k][j]  <= {qin[j][mhd_c2p_pkg::DIVIDEND_W-2:0], fits};
      end
    end
  end

  assign out_valid = vld[STAGES-1];

  for (genvar j = 0; j < NL; j++) begin : g_out
    assign quotient[j] = nq[STAGES-1][j];
  end

endmodule

// ===== hw/rtl/mhd_conservative_to_primitive_core.sv =====
// ----------------------------------------------------------------------------
// MHD conservative-to-primitive core
// Converts one 3D ideal-MHD cell from conserved to primitive variables.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the eight conserved fields and raise start; a beat is taken at any
//   edge with start high and busy low. busy stays low: a new cell may enter
//   every cycle.
//   Each result is shown for one cycle with done high, once its start beat
//   has passed all of the stages named below.
//   Results leave in arrival order, one per cycle at full rate.
//   The path runs through the 64-stage restoring divider that forms the three
//   velocities and the kinetic term, plus three front and five back stages
//   (squares, sums, half sum, difference, magnitude, gamma multiply, output).
//   gamma_we with gamma_minus_one writes the adiabatic register; write it only
//   while no cell is in flight.
//   Reset (rst, synchronous) empties the pipeline and loads gamma - 1 = 2/3.
//   The receiver cannot stall: done is a strobe and must be taken as shown.
//   A density of zero or below sets bad_density and zeroes velocity/pressure.
// ----------------------------------------------------------------------------
module mhd_conservative_to_primitive_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [31:0]                  density_in,
  input  logic signed [31:0]                  momentum_x,
  input  logic signed [31:0]                  momentum_y,
  input  logic signed [31:0]                  momentum_z,
  input  logic signed [31:0]                  field_x_in,
  input  logic signed [31:0]                  field_y_in,
  input  logic signed [31:0]                  field_z_in,
  input  logic signed [31:0]                  total_energy,
  input  logic                                gamma_we,
  input  logic [mhd_c2p_pkg::GAMMA_W-1:0]     gamma_minus_one,
  output logic                                done,
  output logic signed [31:0]                  density_out,
  output logic signed [31:0]                  velocity_x,
  output logic signed [31:0]                  velocity_y,
  output logic signed [31:0]                  velocity_z,
  output logic signed [31:0]                  field_x_out,
  output logic signed [31:0]                  field_y_out,
  output logic signed [31:0]                  field_z_out,
  output logic signed [31:0]                  pressure,
  output logic                                bad_density
);

  localparam int W      = mhd_c2p_pkg::WORD_W;
  localparam int STAGES = mhd_c2p_pkg::DIVIDEND_W;
  localparam int DIFF_W = mhd_c2p_pkg::DIVIDEND_W + 2;
  localparam int DM_W   = 47;
  localparam int PROD_W = DM_W + mhd_c2p_pkg::GAMMA_W;

  logic [mhd_c2p_pkg::GAMMA_W-1:0] gamma;

  // stage 0: input register with magnitudes
  logic                   s0_valid;
  logic [W-1:0]           s0_rho;
  logic [2:0][W-1:0]      s0_field;
  logic [W-1:0]           s0_energy;
  logic [W-1:0]           s0_m_mag [3];
  logic [W-1:0]           s0_b_mag [3];
  logic [2:0]             s0_m_neg;
  logic                   s0_bad;

  // stage 1: squares
  logic                   s1_valid;
  logic [W-1:0]           s1_rho;
  logic [2:0][W-1:0]      s1_field;
  logic [W-1:0]           s1_energy;
  logic [W-1:0]           s1_m_mag [3];
  logic [63:0]            s1_m_sq [3];
  logic [63:0]            s1_b_sq [3];
  logic [2:0]             s1_m_neg;
  logic                   s1_bad;

  // stage 2: sums and divider operands
  logic                   s2_valid;
  logic [63:0]            s2_msq;
  mhd_c2p_pkg::dividend_t s2_vdiv [3];
  mhd_c2p_pkg::side_t     s2_side;

  mhd_c2p_pkg::dividend_t [mhd_c2p_pkg::LANES-1:0] div_in;
  mhd_c2p_pkg::dividend_t [mhd_c2p_pkg::LANES-1:0] quot;
  logic                                            div_valid;
  mhd_c2p_pkg::side_t                              side_pipe [STAGES];
  mhd_c2p_pkg::side_t                              dside;

  // back stages
  logic                   p1_valid;
  mhd_c2p_pkg::res_t      p1_res;
  logic [63:0]            p1_half;
  logic [W-1:0]           p1_energy;

  logic                   p2_valid;
  mhd_c2p_pkg::res_t      p2_res;
  logic [DIFF_W-1:0]      p2_diff;

  logic                   p3_valid;
  mhd_c2p_pkg::res_t      p3_res;
  logic [DIFF_W-1:0]      p3_mag;
  logic                   p3_neg;

  logic                   p4_valid;
  mhd_c2p_pkg::res_t      p4_res;
  logic [PROD_W-1:0]      p4_prod;
  logic                   p4_big;
  logic                   p4_neg;
  logic                   p4_gzero;

  logic [63:0]            pres_mag;
  logic [W-1:0]           pres_val;
  logic [W-1:0]           in_m [3];
  logic [W-1:0]           in_b [3];

  assign busy = 1'b0;

  assign in_m[0] = momentum_x;
  assign in_m[1] = momentum_y;
  assign in_m[2] = momentum_z;
  assign in_b[0] = field_x_in;
  assign in_b[1] = field_y_in;
  assign in_b[2] = field_z_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= mhd_c2p_pkg::GAMMA_RESET;
    end else if (gamma_we) begin
      gamma <= gamma_minus_one;
    end
  end

  // valid chain outside the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      p1_valid <= div_valid;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
      done     <= p4_valid;
    end
  end

  always_ff @(posedge clk) begin
    s0_rho    <= density_in;
    s0_field  <= {field_z_in, field_y_in, field_x_in};
    s0_energy <= total_energy;
    s0_bad    <= density_in[W-1] || (density_in == '0);
    for (int i = 0; i < 3; i++) begin
      s0_m_mag[i] <= mhd_c2p_pkg::abs_word(in_m[i]);
      s0_b_mag[i] <= mhd_c2p_pkg::abs_word(in_b[i]);
      s0_m_neg[i] <= in_m[i][W-1];
    end
  end

  always_ff @(posedge clk) begin
    s1_rho    <= s0_rho;
    s1_field  <= s0_field;
    s1_energy <= s0_energy;
    s1_bad    <= s0_bad;
    s1_m_neg  <= s0_m_neg;
    for (int i = 0; i < 3; i++) begin
      s1_m_mag[i] <= s0_m_mag[i];
      s1_m_sq[i]  <= 64'(s0_m_mag[i]) * 64'(s0_m_mag[i]);
      s1_b_sq[i]  <= 64'(s0_b_mag[i]) * 64'(s0_b_mag[i]);
    end
  end

  always_ff @(posedge clk) begin
    s2_msq          <= s1_m_sq[0] + s1_m_sq[1] + s1_m_sq[2];
    s2_side.density <= s1_rho;
    s2_side.field   <= s1_field;
    s2_side.energy  <= s1_energy;
    s2_side.m_neg   <= s1_m_neg;
    s2_side.bad     <= s1_bad;
    s2_side.bsq     <= mhd_c2p_pkg::BSQ_W'(s1_b_sq[0] >> mhd_c2p_pkg::FRAC_BITS)
                     + mhd_c2p_pkg::BSQ_W'(s1_b_sq[1] >> mhd_c2p_pkg::FRAC_BITS)
                     + mhd_c2p_pkg::BSQ_W'(s1_b_sq[2] >> mhd_c2p_pkg::FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      s2_vdiv[i] <= mhd_c2p_pkg::dividend_t'(s1_m_mag[i]) << mhd_c2p_pkg::FRAC_BITS;
    end
  end

  assign div_in[0]                     = s2_vdiv[0];
  assign div_in[1]                     = s2_vdiv[1];
  assign div_in[2]                     = s2_vdiv[2];
  assign div_in[mhd_c2p_pkg::KIN_LANE] = s2_msq;

  mhd_c2p_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .divisor   (s2_side.density[mhd_c2p_pkg::DIVISOR_W-1:0]),
    .dividend  (div_in),
    .out_valid (div_valid),
    .quotient  (quot)
  );

  // side data rides alongside the divider stages
  always_ff @(posedge clk) begin
    side_pipe[0] <= s2_side;
    for (int k = 1; k < STAGES; k++) begin
      side_pipe[k] <= side_pipe[k-1];
    end
  end

  assign dside = side_pipe[STAGES-1];

  always_ff @(posedge clk) begin
    p1_res.density <= dside.density;
    p1_res.field   <= dside.field;
    p1_res.bad     <= dside.bad;
    p1_energy      <= dside.energy;
    p1_half        <= 64'((65'(quot[mhd_c2p_pkg::KIN_LANE]) + 65'(dside.bsq)) >> 1);
    for (int i = 0; i < 3; i++) begin
      p1_res.vel[i] <= dside.bad ? '0 : mhd_c2p_pkg::sat_word(dside.m_neg[i], quot[i]);
    end
  end

  always_ff @(posedge clk) begin
    p2_res  <= p1_res;
    p2_diff <= {{(DIFF_W-W){p1_energy[W-1]}}, p1_energy} - {2'b00, p1_half};
  end

  always_ff @(posedge clk) begin
    p3_res <= p2_res;
    p3_neg <= p2_diff[DIFF_W-1];
    p3_mag <= p2_diff[DIFF_W-1] ? (~p2_diff + DIFF_W'(1)) : p2_diff;
  end

  always_ff @(posedge clk) begin
    p4_res   <= p3_res;
    p4_neg   <= p3_neg;
    p4_big   <= |p3_mag[DIFF_W-1:DM_W];
    p4_gzero <= (gamma == '0);
    p4_prod  <= PROD_W'(p3_mag[DM_W-1:0]) * PROD_W'(gamma);
  end

  // a difference of 2^47 or more saturates unless gamma is zero
  assign pres_mag = p4_big ? 64'h8000_0001 : 64'(p4_prod >> mhd_c2p_pkg::GAMMA_FRAC);
  assign pres_val = (p4_gzero || p4_res.bad) ? '0 : mhd_c2p_pkg::sat_word(p4_neg, pres_mag);

  always_ff @(posedge clk) begin
    density_out <= p4_res.density;
    field_x_out <= p4_res.field[0];
    field_y_out <= p4_res.field[1];
    field_z_out <= p4_res.field[2];
    velocity_x  <= p4_res.vel[0];
    velocity_y  <= p4_res.vel[1];
    velocity_z  <= p4_res.vel[2];
    pressure    <= pres_val;
    bad_density <= p4_res.bad;
  end

endmodule

// ===== hw/rtl/mhd_c2p_chk.sv =====
// ----------------------------------------------------------------------------
// MHD conservative-to-primitive port checker
// Watches the core's ports for latency and error-flag consistency.
// ----------------------------------------------------------------------------
`include "mhd_conservative_to_primitive_core_assert.svh"

module mhd_c2p_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic signed [31:0]              density_in,
  input logic signed [31:0]              momentum_x,
  input logic signed [31:0]              momentum_y,
  input logic signed [31:0]              momentum_z,
  input logic signed [31:0]              field_x_in,
  input logic signed [31:0]              field_y_in,
  input logic signed [31:0]              field_z_in,
  input logic signed [31:0]              total_energy,
  input logic                            gamma_we,
  input logic [mhd_c2p_pkg::GAMMA_W-1:0] gamma_minus_one,
  input logic                            done,
  input logic signed [31:0]              density_out,
  input logic signed [31:0]              velocity_x,
  input logic signed [31:0]              velocity_y,
  input logic signed [31:0]              velocity_z,
  input logic signed [31:0]              field_x_out,
  input logic signed [31:0]              field_y_out,
  input logic signed [31:0]              field_z_out,
  input logic signed [31:0]              pressure,
  input logic                            bad_density
);

  localparam int LAT = mhd_c2p_pkg::LATENCY;

  // every result beat traces back to a start beat a fixed latency earlier
  `MHD_CHECK_PAST(a_done_latency, done, start && !busy, LAT)

  `MHD_CHECK(a_bad_zeroes, done && bad_density, velocity_x == 0 && velocity_y == 0 && velocity_z == 0 && pressure == 0)

  `MHD_CHECK(a_good_positive, done && !bad_density, density_out > 0)

  `MHD_CHECK(a_bad_nonpositive, done && bad_density, density_out <= 0)

endmodule

bind mhd_conservative_to_primitive_core mhd_c2p_chk u_chk (.*);
